// ===== rtl/fkc_pkg.sv =====
// Shared types and constants for the FIFO-replacement key cache.
// Used by the controller, the datapath and the top level; depends on nothing.
package fkc_pkg;

    localparam int CACHE_DEPTH = 16;
    localparam int IDX_W       = $clog2(CACHE_DEPTH);
    localparam int OCC_W       = $clog2(CACHE_DEPTH + 1);
    localparam int CAP_W       = 5;
    localparam int KEY_W       = 64;
    localparam int HANDLE_W    = 64;
    localparam int OP_W        = 2;
    localparam int S_TDATA_W   = KEY_W + HANDLE_W;
    localparam int M_FIELDS_W  = 1 + HANDLE_W + 1 + 1;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(CACHE_DEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESOLVE,
        ST_EVICT,
        ST_INSERT,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch the incoming transaction, clear result flags
        logic resolve;   // compare keys, record hit, drop on delete hit
        logic evict;     // drop the oldest entry
        logic insert;    // store the new entry as youngest
        logic publish;   // move the result into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        opcode_t op;
        logic    hit;
        logic    need_evict;
        logic    out_busy;
    } status_t;

endpackage

// ===== rtl/fkc_ctrl.sv =====
// Sequencing state machine for the key cache.
// Depends on fkc_pkg; drives commands into fkc_dp and reads its status.
module fkc_ctrl
    import fkc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_RESOLVE;
                end
            end
            ST_RESOLVE: begin
                cmd.resolve = 1'b1;
                if (status.op == OP_INSERT && !status.hit) begin
                    state_next = ST_EVICT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_EVICT: begin
                // drop one oldest entry per cycle until there is room
                if (status.need_evict) begin
                    cmd.evict = 1'b1;
                end else begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT: begin
                cmd.insert = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!status.out_busy) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/fkc_dp.sv =====
// Entry storage, parallel key compare, age-rank update and output register.
// Depends on fkc_pkg; steered by cmd_t from fkc_ctrl.
module fkc_dp
    import fkc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cmd_t                   cmd,
    output status_t                status,
    input  logic [OP_W-1:0]        in_op,
    input  logic [S_TDATA_W-1:0]   in_data,
    input  logic                   cfg_wr_en,
    input  logic [CAP_W-1:0]       cfg_wr_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [M_TDATA_W-1:0]   out_data
);

    // transaction registers
    opcode_t             op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [HANDLE_W-1:0] new_handle_reg;

    // entries
    logic [CACHE_DEPTH-1:0] valid_reg, valid_next;
    logic [KEY_W-1:0]       ekey_reg    [CACHE_DEPTH];
    logic [HANDLE_W-1:0]    ehandle_reg [CACHE_DEPTH];
    logic [IDX_W-1:0]       rank_reg    [CACHE_DEPTH];
    logic [IDX_W-1:0]       rank_next   [CACHE_DEPTH];
    logic [OCC_W-1:0]       occ_reg, occ_next;
    logic [CAP_W-1:0]       cap_reg;

    // result and output registers
    logic                  res_hit_reg, res_ins_reg, res_evc_reg;
    logic [HANDLE_W-1:0]   res_hout_reg;
    logic                  out_valid_reg;
    logic [M_TDATA_W-1:0]  out_data_reg;

    logic [CACHE_DEPTH-1:0] match, oldest, drop_mask;
    logic                   hit_any;
    logic [IDX_W-1:0]       hit_slot, free_slot, drop_rank;
    logic [HANDLE_W-1:0]    hit_handle;
    logic [CAP_W-1:0]       cap_eff;

    always_comb begin
        hit_slot   = '0;
        free_slot  = '0;
        hit_handle = '0;
        for (int i = CACHE_DEPTH - 1; i >= 0; i--) begin
            match[i]  = valid_reg[i] && (ekey_reg[i] == key_reg);
            oldest[i] = valid_reg[i] && (rank_reg[i] == '0);
            if (match[i]) begin
                hit_slot = IDX_W'(i);
            end
            if (!valid_reg[i]) begin
                free_slot = IDX_W'(i);
            end
        end
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            if (match[i]) begin
                hit_handle = hit_handle | ehandle_reg[i];
            end
        end
        hit_any = |match;
    end

    // Clamp capacity into 1..CACHE_DEPTH
    always_comb begin
        priority if (cap_reg == '0) begin
            cap_eff = CAP_W'(1);
        end else if (cap_reg > CAP_W'(CACHE_DEPTH)) begin
            cap_eff = CAP_W'(CACHE_DEPTH);
        end else begin
            cap_eff = cap_reg;
        end
    end

    assign status.op         = op_reg;
    assign status.hit        = hit_any;
    assign status.need_evict = (CAP_W'(occ_reg) >= cap_eff);
    assign status.out_busy   = out_valid_reg && !out_ready;

    // Drop one entry (delete hit or oldest) and close the gap in the age order;
    // or place a new entry as the youngest.
    always_comb begin
        drop_mask = '0;
        drop_rank = '0;
        if (cmd.evict) begin
            drop_mask = oldest;
        end else if (cmd.resolve && op_reg == OP_DELETE) begin
            drop_mask = match;
            drop_rank = rank_reg[hit_slot];
        end
        valid_next = valid_reg & ~drop_mask;
        occ_next   = occ_reg;
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            rank_next[i] = rank_reg[i];
            if (|drop_mask && valid_next[i] && rank_reg[i] > drop_rank) begin
                rank_next[i] = rank_reg[i] - IDX_W'(1);
            end
        end
        if (|drop_mask) begin
            occ_next = occ_reg - OCC_W'(1);
        end
        if (cmd.insert) begin
            valid_next[free_slot] = 1'b1;
            rank_next[free_slot]  = occ_reg[IDX_W-1:0];
            occ_next              = occ_reg + OCC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            occ_reg       <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (cmd.publish) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            rank_reg[i] <= rank_next[i];
        end
        if (cmd.insert) begin
            ekey_reg[free_slot]    <= key_reg;
            ehandle_reg[free_slot] <= new_handle_reg;
        end
        if (cmd.capture) begin
            op_reg         <= opcode_t'(in_op);
            key_reg        <= in_data[KEY_W-1:0];
            new_handle_reg <= in_data[S_TDATA_W-1:KEY_W];
            res_hit_reg    <= 1'b0;
            res_hout_reg   <= '0;
            res_ins_reg    <= 1'b0;
            res_evc_reg    <= 1'b0;
        end
        if (cmd.resolve) begin
            res_hit_reg  <= hit_any && (op_reg != OP_NOP);
            res_hout_reg <= (op_reg == OP_LOOKUP && hit_any) ? hit_handle : '0;
        end
        if (cmd.evict) begin
            res_evc_reg <= 1'b1;
        end
        if (cmd.insert) begin
            res_ins_reg <= 1'b1;
        end
        if (cmd.publish) begin
            out_data_reg <= M_TDATA_W'({res_evc_reg, res_ins_reg, res_hout_reg, res_hit_reg});
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/fifo_replacement_key_cache.sv =====
// Sequence: accept, resolve, then load the result into the output register (m_tvalid);
//   a new insert first passes the evict state (oldest entries out) and the insert state.
// Flow: one transaction in flight; the next is accepted in the cycle after the
//   result is loaded. Loading waits while the output register stays full and m_tready
//   is low.
// Reset (aresetn low, synchronous): all entries invalid, occupancy 0, capacity 16,
//   output register empty.
module fifo_replacement_key_cache
    import fkc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // [63:0] slice_key, [127:64] slice_handle
    input  logic [OP_W-1:0]       s_tuser,  // [1:0] opcode
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,  // [0] hit, [64:1] handle_out, [65] inserted,
                                            // [66] evicted, [71:67] zero
    // capacity register
    input  logic                  cfg_wr_en,
    input  logic [CAP_W-1:0]      cfg_wr_data
);

    cmd_t    cmd;
    status_t status;

    // Sequencer: accept, resolve, evict loop, insert, hand off to output register
    fkc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Entries, 16-way key compare, age ranks and the result register.
    // The output register decouples the result from the next transaction:
    // a new transaction is taken while the previous result still waits.
    fkc_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .in_op       (s_tuser),
        .in_data     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (m_tdata)
    );

endmodule

// ===== rtl/fkc_checker.sv =====
// Port-level checks for the key cache, bound to the top level.
// Depends on fkc_pkg widths only.
module fkc_checker
    import fkc_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata
);

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // one transaction in flight at a time
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction accepted while busy");

    // eviction only comes with a new entry, which is never a hit
    a_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[66] |-> m_tdata[65] && !m_tdata[0])
        else $error("eviction without insertion");

    // a nonzero handle comes only with a hit and never with an insertion
    a_handle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[64:1] != '0 |-> m_tdata[0] && !m_tdata[65])
        else $error("handle without hit");

    // output register empties on reset
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind fifo_replacement_key_cache fkc_checker u_fkc_checker (.*);

// ===== dv/fkc_result_scoreboard_pkg.sv =====
// Scoreboard for the FIFO-replacement key cache: a cycle-free model of the cache
// contents and a queue of predicted results. Depends on fkc_pkg for widths and opcodes.
`timescale 1ns / 1ps
package fkc_result_scoreboard_pkg;
    import fkc_pkg::*;

    typedef struct packed {
        logic                hit;
        logic [HANDLE_W-1:0] handle_out;
        logic                inserted;
        logic                evicted;
    } cache_result_t;

    class fkc_result_scoreboard;
        logic [KEY_W-1:0]    keys    [CACHE_DEPTH];
        logic [HANDLE_W-1:0] handles [CACHE_DEPTH];
        bit                  valid   [CACHE_DEPTH];
        int                  age_rank[CACHE_DEPTH];
        int                  occupancy;
        logic [CAP_W-1:0]    capacity;
        cache_result_t       predicted_results[$];
        int                  errors;
        int                  n_checked;
        int                  n_hits;
        int                  n_evict_inserts;

        function new();
            capacity  = CAP_RESET;
            occupancy = 0;
            for (int i = 0; i < CACHE_DEPTH; i++) begin
                valid[i]    = 0;
                age_rank[i] = 0;
            end
            errors          = 0;
            n_checked       = 0;
            n_hits          = 0;
            n_evict_inserts = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            capacity = value;
        endfunction

        function int find_slot(logic [KEY_W-1:0] key);
            for (int i = 0; i < CACHE_DEPTH; i++) begin
                if (valid[i] && keys[i] == key) return i;
            end
            return -1;
        endfunction

        // Invalidate a slot and close the gap in the age order.
        function void drop_slot(int slot);
            int r;
            r = age_rank[slot];
            valid[slot] = 0;
            for (int i = 0; i < CACHE_DEPTH; i++) begin
                if (valid[i] && age_rank[i] > r) age_rank[i]--;
            end
            if (occupancy > 0) occupancy--;
        endfunction

        function void drop_oldest();
            for (int i = 0; i < CACHE_DEPTH; i++) begin
                if (valid[i] && age_rank[i] == 0) begin
                    drop_slot(i);
                    return;
                end
            end
        endfunction

        function void note_request(opcode_t op, logic [KEY_W-1:0] key,
                                   logic [HANDLE_W-1:0] handle);
            cache_result_t res;
            int            slot;
            int            eff_cap;
            res  = '0;
            slot = find_slot(key);
            case (op)
                OP_LOOKUP: begin
                    if (slot >= 0) begin
                        res.hit        = 1'b1;
                        res.handle_out = handles[slot];
                    end
                end
                OP_INSERT: begin
                    if (slot >= 0) begin
                        res.hit = 1'b1;
                    end else begin
                        eff_cap = int'(capacity);
                        if (eff_cap == 0) eff_cap = 1;
                        if (eff_cap > CACHE_DEPTH) eff_cap = CACHE_DEPTH;
                        while (occupancy >= eff_cap && occupancy > 0) begin
                            drop_oldest();
                            res.evicted = 1'b1;
                        end
                        for (int i = 0; i < CACHE_DEPTH; i++) begin
                            if (!valid[i]) begin
                                valid[i]    = 1;
                                keys[i]     = key;
                                handles[i]  = handle;
                                age_rank[i] = occupancy;
                                occupancy++;
                                res.inserted = 1'b1;
                                break;
                            end
                        end
                    end
                end
                OP_DELETE: begin
                    if (slot >= 0) begin
                        res.hit = 1'b1;
                        drop_slot(slot);
                    end
                end
                default: ;
            endcase
            predicted_results.push_back(res);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata);
            cache_result_t want;
            logic [M_TDATA_W-M_FIELDS_W-1:0] pad;
            pad = tdata[M_TDATA_W-1:M_FIELDS_W];
            if (predicted_results.size() == 0) begin
                $display("%0t: result with nothing predicted, tdata %h", $time, tdata);
                errors++;
                return;
            end
            want = predicted_results.pop_front();
            n_checked++;
            if (want.hit) n_hits++;
            if (want.evicted) n_evict_inserts++;
            if (tdata[0] !== want.hit) begin
                $display("%0t: hit expected %b actual %b", $time, want.hit, tdata[0]);
                errors++;
            end
            if (tdata[HANDLE_W:1] !== want.handle_out) begin
                $display("%0t: handle_out expected %h actual %h", $time,
                         want.handle_out, tdata[HANDLE_W:1]);
                errors++;
            end
            if (tdata[HANDLE_W+1] !== want.inserted) begin
                $display("%0t: inserted expected %b actual %b", $time,
                         want.inserted, tdata[HANDLE_W+1]);
                errors++;
            end
            if (tdata[HANDLE_W+2] !== want.evicted) begin
                $display("%0t: evicted expected %b actual %b", $time,
                         want.evicted, tdata[HANDLE_W+2]);
                errors++;
            end
            if (pad !== '0) begin
                $display("%0t: tdata padding expected 0 actual %h", $time, pad);
                errors++;
            end
        endfunction

        function int outstanding();
            return predicted_results.size();
        endfunction
    endclass

endpackage

// ===== dv/fifo_replacement_key_cache_test.sv =====
// Testbench top for fifo_replacement_key_cache: directed and random lookup, insert and
// delete traffic under several capacities, with stalls on both streams.
// Depends on fkc_pkg and fkc_result_scoreboard_pkg.
`timescale 1ns / 1ps
module fifo_replacement_key_cache_test;
    import fkc_pkg::*;
    import fkc_result_scoreboard_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;  // well above the slowest legal run
    localparam int SETTLE_CYCLES = 12;      // idle margin once every result is back
    localparam int POOL_SIZE     = 24;      // more keys than entries, so misses stay common
    localparam int SEGMENT_ITEMS = 100;
    localparam int N_SEGMENTS    = 14;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [63:0] slice_key, [127:64] slice_handle
    logic [OP_W-1:0]      s_tuser;   // [1:0] opcode
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [0] hit, [64:1] handle_out, [65] inserted,
                                     // [66] evicted, [71:67] zero
    logic                 cfg_wr_en;
    logic [CAP_W-1:0]     cfg_wr_data;

    fkc_result_scoreboard tracker;
    logic [KEY_W-1:0]     key_pool[POOL_SIZE];
    int                   send_idle_pct;
    int                   recv_idle_pct;
    int                   n_sent;
    int                   cycle_count;

    fifo_replacement_key_cache uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #4 aclk = ~aclk;

    // Check every result transaction and pick the next ready value at random.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_result(m_tdata);
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Count cycles and abort the run if it hangs.
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, tracker.outstanding());
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Present one transaction and hold it until accepted. Leave tvalid high afterwards
    // so the next call can go back to back; idle gaps lower it first.
    task automatic send_op(input opcode_t op, input logic [KEY_W-1:0] key,
                           input logic [HANDLE_W-1:0] handle);
        if (send_idle_pct > 0) begin
            while ($urandom_range(0, 99) < send_idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {handle, key};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        // Accepted at this edge: note it before the result can appear.
        tracker.note_request(op, key, handle);
        n_sent++;
    endtask

    // Drop tvalid, wait for every predicted result, then let the block go idle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write the capacity register only once the block is idle.
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.set_capacity(value);
    endtask

    // Mostly keys from the pool so hits, refusals and deletes of held keys happen;
    // a tenth of the keys are fresh noise.
    task automatic send_random_op();
        int               r;
        opcode_t          op;
        logic [KEY_W-1:0] key;
        logic [HANDLE_W-1:0] handle;
        r = $urandom_range(0, 99);
        if (r < 30)      op = OP_LOOKUP;
        else if (r < 65) op = OP_INSERT;
        else if (r < 93) op = OP_DELETE;
        else             op = OP_NOP;
        if ($urandom_range(0, 9) == 0) key = rand64();
        else                           key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        r = $urandom_range(0, 19);
        if (r == 0)      handle = '0;
        else if (r == 1) handle = '1;
        else             handle = rand64();
        send_op(op, key, handle);
    endtask

    initial begin
        logic [CAP_W-1:0] seg_capacity[N_SEGMENTS];
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = OP_LOOKUP;
        m_tready      = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        send_idle_pct = 34;
        recv_idle_pct = 49;
        n_sent        = 0;
        tracker       = new();

        // Extremes plus keys that differ from key_pool[2] in only the lowest or the highest bit.
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = rand64();
        key_pool[3] = key_pool[2] ^ 64'h1;
        key_pool[4] = key_pool[2] ^ 64'h8000_0000_0000_0000;

        seg_capacity = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd31, 5'd8, 5'd2,
                         5'd16, 5'd12, 5'd3, 5'd5, 5'd17, 5'd16, 5'd7};

        // Hold reset low, then release it for good.
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty cache, extreme keys and handles, every opcode.
        send_op(OP_LOOKUP, key_pool[0], rand64());    // miss on an empty cache
        send_op(OP_DELETE, key_pool[0], rand64());    // delete of an absent key
        send_op(OP_INSERT, key_pool[0], '1);
        send_op(OP_INSERT, key_pool[1], '0);
        send_op(OP_LOOKUP, key_pool[0], '0);          // hit, all-ones handle
        send_op(OP_LOOKUP, key_pool[1], '1);          // hit, zero handle
        send_op(OP_INSERT, key_pool[0], rand64());    // refused: key already held
        send_op(OP_LOOKUP, key_pool[3], '0);          // miss: one bit from key_pool[2], which is not held
        send_op(OP_NOP,    key_pool[0], '1);          // no operation, all-zero result
        send_op(OP_DELETE, key_pool[1], '0);          // delete of a held key
        send_op(OP_LOOKUP, key_pool[1], '0);          // gone after delete
        send_op(OP_INSERT, key_pool[5], rand64());
        send_op(OP_INSERT, key_pool[6], rand64());
        send_op(OP_INSERT, key_pool[7], rand64());
        send_op(OP_DELETE, key_pool[5], '0);          // delete from the middle of the order
        // Lower capacity below occupancy: next insert evicts the two oldest entries.
        write_capacity(5'd2);
        send_op(OP_INSERT, key_pool[8], rand64());
        send_op(OP_LOOKUP, key_pool[7], '0);
        send_op(OP_LOOKUP, key_pool[6], '0);
        // Capacity zero behaves as one.
        write_capacity(5'd0);
        send_op(OP_INSERT, key_pool[9], rand64());
        send_op(OP_LOOKUP, key_pool[8], '0);
        // Capacity above the depth behaves as the full depth.
        write_capacity(5'd31);
        send_op(OP_INSERT, key_pool[10], rand64());
        send_op(OP_INSERT, key_pool[11], rand64());
        send_op(OP_LOOKUP, key_pool[10], '0);

        // Random: one capacity per segment; receiver-heavy idling, then sender-heavy,
        // then full rate.
        for (int seg = 0; seg < N_SEGMENTS; seg++) begin
            if (seg == 5) begin
                send_idle_pct = 49;
                recv_idle_pct = 34;
            end else if (seg == 10) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_capacity(seg_capacity[seg]);
            for (int n = 0; n < SEGMENT_ITEMS; n++) send_random_op();
        end

        // Wait out the tail, then report.
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("sent %0d transactions, directed plus %0d random capacity segments, %0s %0d",
                 n_sent, N_SEGMENTS, "checked results:", tracker.n_checked);
        $display("results with hit set: %0d, inserts that evicted: %0d",
                 tracker.n_hits, tracker.n_evict_inserts);
        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
